FILE: src/lkf_pkg.sv
package lkf_pkg;

  // Scratch memory layout, one 32-bit word per matrix or vector element.
  localparam int unsigned AW        = 7;
  localparam int unsigned MEM_DEPTH = 128;

  localparam logic [AW-1:0] X_BASE   = 7'd0;
  localparam logic [AW-1:0] XN_BASE  = 7'd4;
  localparam logic [AW-1:0] Y_BASE   = 7'd8;
  localparam logic [AW-1:0] DET_ADDR = 7'd13;
  localparam logic [AW-1:0] NUM_ADDR = 7'd14;
  localparam logic [AW-1:0] P_BASE   = 7'd16;
  localparam logic [AW-1:0] F_BASE   = 7'd32;
  localparam logic [AW-1:0] H_BASE   = 7'd48;
  localparam logic [AW-1:0] R_BASE   = 7'd56;
  localparam logic [AW-1:0] S_BASE   = 7'd60;
  localparam logic [AW-1:0] Q_BASE   = 7'd64;
  localparam logic [AW-1:0] T_BASE   = 7'd80;
  localparam logic [AW-1:0] A_BASE   = 7'd96;
  localparam logic [AW-1:0] PH_BASE  = 7'd112;
  localparam logic [AW-1:0] K_BASE   = 7'd120;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_PREDICT = 2'd1,
    REQ_UPDATE  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    SEL_STATE  = 3'd0,
    SEL_COV    = 3'd1,
    SEL_TRANS  = 3'd2,
    SEL_MEAS   = 3'd3,
    SEL_MNOISE = 3'd4,
    SEL_PNOISE = 3'd5
  } sel_e;

  // What one accumulator term does.
  typedef enum logic [2:0] {
    TK_NOP,
    TK_MUL_ADD,
    TK_MUL_SUB,
    TK_ADD,
    TK_ONE,
    TK_Z
  } term_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_WRITE,
    ST_DIV_RD,
    ST_DIV_LD,
    ST_DIV_RUN,
    ST_DIV_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic          term_vld;
    term_e         kind;
    logic [AW-1:0] a_addr;
    logic [AW-1:0] b_addr;
    logic          acc_clr;
    logic          wr_acc;
    logic          wr_div;
    logic [AW-1:0] wr_addr;
    logic          div_start;
    logic          load_wr;
    logic          in_latch;
    logic          out_load;
    logic          out_singular;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic div_busy;
    logic out_free;
  } stat_t;

  function automatic logic [AW-1:0] at(input logic [AW-1:0] base, input logic [3:0] off);
    return base + {{(AW-4){1'b0}}, off};
  endfunction

  // Saturate to 32-bit signed; the top bit reports that clipping happened.
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (v < -64'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end else begin
      return {1'b0, v[31:0]};
    end
  endfunction

endpackage

FILE: src/lkf_ctrl.sv
module lkf_ctrl
  import lkf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  [1:0] req_i,
  output logic  in_ready_o,
  input  stat_t st_i,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    PH_XN, PH_T, PH_PP, PH_XC,
    PH_Y, PH_PH, PH_S, PH_DET, PH_NUM, PH_A, PH_PN, PH_XU, PH_PC
  } phase_e;

  typedef struct packed {
    logic [1:0] ilast;
    logic [1:0] jlast;
    logic [2:0] klast;
  } dims_t;

  typedef struct packed {
    term_e         kind;
    logic [AW-1:0] a;
    logic [AW-1:0] b;
  } term_t;

  function automatic dims_t phase_dims(input phase_e ph);
    dims_t d;
    d = '{ilast: 2'd3, jlast: 2'd3, klast: 3'd3};
    unique case (ph)
      PH_XN:  d = '{ilast: 2'd3, jlast: 2'd0, klast: 3'd3};
      PH_T:   d = '{ilast: 2'd3, jlast: 2'd3, klast: 3'd3};
      PH_PP:  d = '{ilast: 2'd3, jlast: 2'd3, klast: 3'd4};
      PH_XC:  d = '{ilast: 2'd3, jlast: 2'd0, klast: 3'd0};
      PH_Y:   d = '{ilast: 2'd1, jlast: 2'd0, klast: 3'd4};
      PH_PH:  d = '{ilast: 2'd3, jlast: 2'd1, klast: 3'd3};
      PH_S:   d = '{ilast: 2'd1, jlast: 2'd1, klast: 3'd4};
      PH_DET: d = '{ilast: 2'd0, jlast: 2'd0, klast: 3'd1};
      PH_NUM: d = '{ilast: 2'd3, jlast: 2'd1, klast: 3'd1};
      PH_A:   d = '{ilast: 2'd3, jlast: 2'd3, klast: 3'd2};
      PH_PN:  d = '{ilast: 2'd3, jlast: 2'd3, klast: 3'd3};
      PH_XU:  d = '{ilast: 2'd3, jlast: 2'd0, klast: 3'd2};
      PH_PC:  d = '{ilast: 2'd3, jlast: 2'd3, klast: 3'd0};
      default: d = '{ilast: 2'd0, jlast: 2'd0, klast: 3'd0};
    endcase
    return d;
  endfunction

  function automatic phase_e next_phase(input phase_e ph);
    phase_e n;
    unique case (ph)
      PH_XN:   n = PH_T;
      PH_T:    n = PH_PP;
      PH_PP:   n = PH_XC;
      PH_Y:    n = PH_PH;
      PH_PH:   n = PH_S;
      PH_S:    n = PH_DET;
      PH_DET:  n = PH_NUM;
      PH_NUM:  n = PH_A;
      PH_A:    n = PH_PN;
      PH_PN:   n = PH_XU;
      PH_XU:   n = PH_PC;
      default: n = PH_XN;
    endcase
    return n;
  endfunction

  function automatic logic [AW-1:0] dest_addr(input phase_e ph, input logic [1:0] i,
                                               input logic [1:0] j);
    logic [AW-1:0] a;
    a = X_BASE;
    unique case (ph)
      PH_XN:  a = at(XN_BASE, {2'b00, i});
      PH_T:   a = at(T_BASE, {i, j});
      PH_PP:  a = at(P_BASE, {i, j});
      PH_XC:  a = at(X_BASE, {2'b00, i});
      PH_Y:   a = at(Y_BASE, {2'b00, i});
      PH_PH:  a = at(PH_BASE, {1'b0, i, j[0]});
      PH_S:   a = at(S_BASE, {2'b00, i[0], j[0]});
      PH_DET: a = DET_ADDR;
      PH_NUM: a = NUM_ADDR;
      PH_A:   a = at(A_BASE, {i, j});
      PH_PN:  a = at(T_BASE, {i, j});
      PH_XU:  a = at(X_BASE, {2'b00, i});
      PH_PC:  a = at(P_BASE, {i, j});
      default: a = X_BASE;
    endcase
    return a;
  endfunction

  // Operand addresses and kind of term k of element (i, j) in a phase. Where a
  // phase adds a stored term, it comes first and the products follow.
  function automatic term_t term_cmd(input phase_e ph, input logic [1:0] i,
                                     input logic [1:0] j, input logic [2:0] k);
    term_t      t;
    logic [1:0] kk;
    logic [1:0] kp;
    logic       first;
    kk    = k[1:0];
    kp    = 2'(k - 3'd1);
    first = (k == 3'd0);
    t     = '{kind: TK_NOP, a: X_BASE, b: X_BASE};
    unique case (ph)
      PH_XN: t = '{kind: TK_MUL_ADD, a: at(F_BASE, {i, kk}), b: at(X_BASE, {2'b00, kk})};
      PH_T:  t = '{kind: TK_MUL_ADD, a: at(F_BASE, {i, kk}), b: at(P_BASE, {kk, j})};
      PH_PP: begin
        if (first) t = '{kind: TK_ADD, a: at(Q_BASE, {i, j}), b: X_BASE};
        else t = '{kind: TK_MUL_ADD, a: at(T_BASE, {i, kp}), b: at(F_BASE, {j, kp})};
      end
      PH_XC: t = '{kind: TK_ADD, a: at(XN_BASE, {2'b00, i}), b: X_BASE};
      PH_Y: begin
        if (first) t = '{kind: TK_Z, a: at(X_BASE, {3'b000, i[0]}), b: X_BASE};
        else t = '{kind: TK_MUL_SUB, a: at(H_BASE, {i, kp}), b: at(X_BASE, {2'b00, kp})};
      end
      PH_PH: t = '{kind: TK_MUL_ADD, a: at(P_BASE, {i, kk}), b: at(H_BASE, {j, kk})};
      PH_S: begin
        if (first) t = '{kind: TK_ADD, a: at(R_BASE, {2'b00, i[0], j[0]}), b: X_BASE};
        else t = '{kind: TK_MUL_ADD, a: at(H_BASE, {i, kp}),
                   b: at(PH_BASE, {1'b0, kp, j[0]})};
      end
      PH_DET: begin
        if (first) t = '{kind: TK_MUL_ADD, a: S_BASE, b: at(S_BASE, 4'd3)};
        else t = '{kind: TK_MUL_SUB, a: at(S_BASE, 4'd1), b: at(S_BASE, 4'd2)};
      end
      PH_NUM: begin
        // Adjugate of S: column 0 uses s11 and s10, column 1 uses s00 and s01.
        if (!j[0]) begin
          if (first) t = '{kind: TK_MUL_ADD, a: at(PH_BASE, {1'b0, i, 1'b0}),
                           b: at(S_BASE, 4'd3)};
          else t = '{kind: TK_MUL_SUB, a: at(PH_BASE, {1'b0, i, 1'b1}),
                     b: at(S_BASE, 4'd2)};
        end else begin
          if (first) t = '{kind: TK_MUL_ADD, a: at(PH_BASE, {1'b0, i, 1'b1}), b: S_BASE};
          else t = '{kind: TK_MUL_SUB, a: at(PH_BASE, {1'b0, i, 1'b0}),
                     b: at(S_BASE, 4'd1)};
        end
      end
      PH_A: begin
        if (first) t = '{kind: (i == j) ? TK_ONE : TK_NOP, a: X_BASE, b: X_BASE};
        else t = '{kind: TK_MUL_SUB, a: at(K_BASE, {1'b0, i, kp[0]}),
                   b: at(H_BASE, {1'b0, kp[0], j})};
      end
      PH_PN: t = '{kind: TK_MUL_ADD, a: at(A_BASE, {i, kk}), b: at(P_BASE, {kk, j})};
      PH_XU: begin
        if (first) t = '{kind: TK_ADD, a: at(X_BASE, {2'b00, i}), b: X_BASE};
        else t = '{kind: TK_MUL_ADD, a: at(K_BASE, {1'b0, i, kp[0]}),
                   b: at(Y_BASE, {3'b000, kp[0]})};
      end
      PH_PC: t = '{kind: TK_ADD, a: at(T_BASE, {i, j}), b: X_BASE};
      default: t = '{kind: TK_NOP, a: X_BASE, b: X_BASE};
    endcase
    return t;
  endfunction

  state_e     state_q, state_d;
  phase_e     ph_q, ph_d;
  logic [1:0] i_q, i_d, j_q, j_d;
  logic [2:0] k_q, k_d;
  logic       sing_q, sing_d;
  logic       adv;
  dims_t      dims;
  term_t      tc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= PH_XN;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      sing_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      sing_q  <= sing_d;
    end
  end

  always_comb begin
    dims       = phase_dims(ph_q);
    tc         = term_cmd(ph_q, i_q, j_q, k_q);
    state_d    = state_q;
    ph_d       = ph_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    sing_d     = sing_q;
    adv        = 1'b0;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.kind = TK_NOP;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_latch = 1'b1;
          cmd_o.acc_clr  = 1'b1;
          sing_d = 1'b0;
          i_d    = '0;
          j_d    = '0;
          k_d    = '0;
          unique case (req_i)
            REQ_LOAD:    state_d = ST_LOAD;
            REQ_PREDICT: begin
              ph_d    = PH_XN;
              state_d = ST_ISSUE;
            end
            REQ_UPDATE: begin
              ph_d    = PH_Y;
              state_d = ST_ISSUE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_LOAD: begin
        cmd_o.load_wr = 1'b1;
        state_d = ST_DONE;
      end
      ST_ISSUE: begin
        cmd_o.term_vld = 1'b1;
        cmd_o.kind     = tc.kind;
        cmd_o.a_addr   = tc.a;
        cmd_o.b_addr   = tc.b;
        if (k_q == dims.klast) begin
          state_d = ST_DRAIN1;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      ST_DRAIN1: state_d = ST_DRAIN2;
      ST_DRAIN2: state_d = ST_WRITE;
      ST_WRITE: begin
        cmd_o.wr_acc  = 1'b1;
        cmd_o.acc_clr = 1'b1;
        cmd_o.wr_addr = dest_addr(ph_q, i_q, j_q);
        if (ph_q == PH_NUM) begin
          state_d = ST_DIV_RD;
        end else begin
          adv = 1'b1;
        end
      end
      ST_DIV_RD: begin
        cmd_o.a_addr = NUM_ADDR;
        cmd_o.b_addr = DET_ADDR;
        state_d = ST_DIV_LD;
      end
      ST_DIV_LD: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (!st_i.div_busy) state_d = ST_DIV_WR;
      end
      ST_DIV_WR: begin
        cmd_o.wr_div  = 1'b1;
        cmd_o.wr_addr = at(K_BASE, {1'b0, i_q, j_q[0]});
        adv = 1'b1;
      end
      ST_DONE: begin
        if (st_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_singular = sing_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (adv) begin
      k_d = '0;
      if (j_q != dims.jlast) begin
        j_d     = j_q + 2'd1;
        state_d = ST_ISSUE;
      end else if (i_q != dims.ilast) begin
        j_d     = '0;
        i_d     = i_q + 2'd1;
        state_d = ST_ISSUE;
      end else begin
        i_d = '0;
        j_d = '0;
        if (ph_q == PH_XC || ph_q == PH_PC) begin
          state_d = ST_DONE;
        end else if (ph_q == PH_DET && st_i.zero) begin
          // A singular innovation covariance ends the update untouched.
          sing_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          ph_d    = next_phase(ph_q);
          state_d = ST_ISSUE;
        end
      end
    end
  end

endmodule

FILE: src/lkf_dp.sv
module lkf_dp
  import lkf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_t         cmd_i,
  output stat_t        st_o,
  input  logic [2:0]   sel_i,
  input  logic [1:0]   row_i,
  input  logic [1:0]   col_i,
  input  logic [31:0]  entry_i,
  input  logic [31:0]  meas_first_i,
  input  logic [31:0]  meas_second_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [127:0] out_data_o,
  output logic [1:0]   out_user_o
);

  localparam int unsigned DVW = 32 + FRAC_BITS;
  localparam int unsigned CW  = $clog2(DVW + 1);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] ONE2 = 64'sd1 <<< (2 * FRAC_BITS);

  logic [31:0] mem [MEM_DEPTH];
  logic [31:0] rda_q, rdb_q;

  logic [2:0]  ld_sel_q;
  logic [1:0]  ld_row_q, ld_col_q;
  logic [31:0] ld_val_q, z0_q, z1_q;

  logic        v1_q, v2_q;
  term_e       kind1_q;
  logic        zsel1_q;
  logic        neg2_q;
  logic signed [63:0] prod_d, prod_q, rnd, acc_q;

  logic [DVW-1:0] dq_q;
  logic [31:0]    rem_q, den_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, dv_neg_q;
  logic [32:0]    rem_sh;
  logic           ge;
  logic [31:0]    magn, magd;
  logic signed [63:0] qmag, qs;

  logic [32:0]   acc_sat, div_sat;
  logic          ld_ok;
  logic [AW-1:0] ld_addr;
  logic          we;
  logic [AW-1:0] wa;
  logic [31:0]   wd;
  logic          sat_q;
  logic [31:0]   est_q [4];

  logic          out_vld_q;
  logic [127:0]  out_data_q;
  logic [1:0]    out_user_q;

  // Two read ports, one write port, registered read data.
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rda_q <= mem[cmd_i.a_addr];
    rdb_q <= mem[cmd_i.b_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_latch) begin
      ld_sel_q <= sel_i;
      ld_row_q <= row_i;
      ld_col_q <= col_i;
      ld_val_q <= entry_i;
      z0_q     <= meas_first_i;
      z1_q     <= meas_second_i;
    end
  end

  // Multiply-accumulate pipeline: read, multiply, round and accumulate.
  always_comb begin
    unique case (kind1_q)
      TK_MUL_ADD, TK_MUL_SUB: prod_d = $signed(rda_q) * $signed(rdb_q);
      TK_ADD:  prod_d = 64'(signed'(rda_q)) <<< FRAC_BITS;
      TK_ONE:  prod_d = ONE2;
      TK_Z:    prod_d = 64'(signed'(zsel1_q ? z1_q : z0_q)) <<< FRAC_BITS;
      default: prod_d = '0;
    endcase
  end

  assign rnd = (prod_q + HALF) >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      kind1_q <= TK_NOP;
    end else begin
      v1_q    <= cmd_i.term_vld;
      v2_q    <= v1_q;
      kind1_q <= cmd_i.kind;
    end
  end

  always_ff @(posedge clk_i) begin
    zsel1_q <= cmd_i.a_addr[0];
    prod_q  <= prod_d;
    neg2_q  <= (kind1_q == TK_MUL_SUB);
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= neg2_q ? acc_q - rnd : acc_q + rnd;
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  assign magn   = rda_q[31] ? (~rda_q + 32'd1) : rda_q;
  assign magd   = rdb_q[31] ? (~rdb_q + 32'd1) : rdb_q;
  assign rem_sh = {rem_q, dq_q[DVW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DVW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q     <= {magn, {FRAC_BITS{1'b0}}};
      rem_q    <= '0;
      den_q    <= magd;
      dv_neg_q <= rda_q[31] ^ rdb_q[31];
    end else if (busy_q) begin
      dq_q  <= {dq_q[DVW-2:0], ge};
      rem_q <= ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
    end
  end

  assign qmag    = $signed({{(64-DVW){1'b0}}, dq_q});
  assign qs      = dv_neg_q ? -qmag : qmag;
  assign acc_sat = sat32(acc_q);
  assign div_sat = sat32(qs);

  always_comb begin
    ld_ok   = 1'b1;
    ld_addr = X_BASE;
    unique case (ld_sel_q)
      SEL_STATE:  ld_addr = at(X_BASE, {2'b00, ld_row_q});
      SEL_COV:    ld_addr = at(P_BASE, {ld_row_q, ld_col_q});
      SEL_TRANS:  ld_addr = at(F_BASE, {ld_row_q, ld_col_q});
      SEL_MEAS: begin
        ld_ok   = !ld_row_q[1];
        ld_addr = at(H_BASE, {1'b0, ld_row_q[0], ld_col_q});
      end
      SEL_MNOISE: begin
        ld_ok   = !ld_row_q[1] && !ld_col_q[1];
        ld_addr = at(R_BASE, {2'b00, ld_row_q[0], ld_col_q[0]});
      end
      SEL_PNOISE: ld_addr = at(Q_BASE, {ld_row_q, ld_col_q});
      default:    ld_ok = 1'b0;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = cmd_i.wr_addr;
    wd = acc_sat[31:0];
    priority if (cmd_i.wr_acc) begin
      we = 1'b1;
    end else if (cmd_i.wr_div) begin
      we = 1'b1;
      wd = div_sat[31:0];
    end else if (cmd_i.load_wr && ld_ok) begin
      we = 1'b1;
      wa = ld_addr;
      wd = ld_val_q;
    end
  end

  // Shadow copy of the state vector feeds the result without memory reads.
  always_ff @(posedge clk_i) begin
    if (we && wa[AW-1:2] == '0) est_q[wa[1:0]] <= wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (cmd_i.in_latch) begin
      sat_q <= 1'b0;
    end else if ((cmd_i.wr_acc && acc_sat[32]) || (cmd_i.wr_div && div_sat[32])) begin
      sat_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {est_q[3], est_q[2], est_q[1], est_q[0]};
      out_user_q <= {sat_q, cmd_i.out_singular};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  assign st_o.zero     = (acc_sat[31:0] == 32'd0);
  assign st_o.div_busy = busy_q;
  assign st_o.out_free = !out_vld_q || out_ready_i;

endmodule

FILE: src/linear_kalman_filter.sv
// Load request: ST_LOAD writes the entry, then ST_DONE loads the result. Predict runs
// on one shared 32x32 multiply-accumulate unit issuing one term a cycle in ST_ISSUE,
// with drain and write states between elements. Update also uses eight gain divisions
// in a divider that yields one quotient bit a cycle, 32+FRAC_BITS bits each.
// One request is in flight at a time; the next is taken while a result waits.
// Reset clears control state only; matrix storage holds no value until loaded.
module linear_kalman_filter
  import lkf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // row_index[1:0], col_index[3:2], entry_value[35:4], meas_first[67:36],
  // meas_second[99:68], zero fill[103:100]
  input  logic [103:0] s_axis_tdata,
  // req_type[1:0], matrix_sel[4:2]
  input  logic [4:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // est_0[31:0], est_1[63:32], est_2[95:64], est_3[127:96]
  output logic [127:0] m_axis_tdata,
  // singular_flag[0], saturated_flag[1]
  output logic [1:0]   m_axis_tuser
);

  cmd_t  cmd;
  stat_t st;

  lkf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .req_i      (s_axis_tuser[1:0]),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  lkf_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .sel_i         (s_axis_tuser[4:2]),
    .row_i         (s_axis_tdata[1:0]),
    .col_i         (s_axis_tdata[3:2]),
    .entry_i       (s_axis_tdata[35:4]),
    .meas_first_i  (s_axis_tdata[67:36]),
    .meas_second_i (s_axis_tdata[99:68]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .out_user_o    (m_axis_tuser)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  a_div_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.div_busy |-> !s_axis_tready)
    else $error("input ready while divider busy");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !m_axis_tvalid || m_axis_tready)
    else $error("result register overwritten before it was taken");

endmodule

FILE: dv/tb_linear_kalman_filter.sv
module tb_linear_kalman_filter;
  import lkf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC = 16;
  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned ITEM_TARGET = 1400;
  localparam logic [1:0] REQ_NOOP = 2'd3;
  localparam logic [2:0] SEL_SPARE6 = 3'd6;
  localparam logic [2:0] SEL_SPARE7 = 3'd7;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  typedef struct packed {
    logic       hold;
    logic [1:0] req;
    logic [2:0] sel;
    logic [1:0] row;
    logic [1:0] col;
    logic [31:0] val;
    logic [31:0] z0;
    logic [31:0] z1;
  } kf_req_t;

  typedef struct packed {
    logic [31:0] e3;
    logic [31:0] e2;
    logic [31:0] e1;
    logic [31:0] e0;
    logic        sat;
    logic        sing;
  } kf_est_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic m_ready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  kf_req_t cur = '0;

  kf_req_t pending[$];
  kf_est_t est_queue[$];
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int unsigned n_in, n_out, n_errors, idle_cycles;
  int unsigned n_load, n_pred, n_upd, n_sing, n_sat;
  int unsigned gap_left, stall_left;
  logic quiet;

  // Filter state as seen by the predictor.
  logic signed [31:0] xv[4];
  logic signed [31:0] pm[16];
  logic signed [31:0] fm[16];
  logic signed [31:0] hm[8];
  logic signed [31:0] rm[4];
  logic signed [31:0] qm[16];
  logic clip;

  linear_kalman_filter #(.FRAC_BITS(FRAC)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  ({4'b0, cur.z1, cur.z0, cur.val, cur.col, cur.row}),
    .s_axis_tuser  ({cur.sel, cur.req}),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Exact product, rounded half up to the fraction width.
  function automatic logic signed [63:0] rmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] aa;
    logic signed [63:0] bb;
    aa = a;
    bb = b;
    return (aa * bb + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic logic signed [31:0] gain(input logic signed [63:0] num,
                                              input logic signed [31:0] det);
    logic signed [63:0] n;
    logic signed [63:0] d;
    n = sat(num);
    d = det;
    return sat((n <<< FRAC) / d);
  endfunction

  function automatic void run_predict();
    logic signed [31:0] xn[4];
    logic signed [31:0] t[16];
    logic signed [63:0] acc;
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc += rmul(fm[i*4+k], xv[k]);
      xn[i] = sat(acc);
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += rmul(fm[i*4+k], pm[k*4+j]);
        t[i*4+j] = sat(acc);
      end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = qm[i*4+j];
        for (int k = 0; k < 4; k++) acc += rmul(t[i*4+k], fm[j*4+k]);
        pm[i*4+j] = sat(acc);
      end
    xv = xn;
  endfunction

  // Returns 1 when S has a zero determinant and nothing is changed.
  function automatic logic run_update(input logic signed [31:0] z0,
                                      input logic signed [31:0] z1);
    logic signed [31:0] y[2];
    logic signed [31:0] s[4];
    logic signed [31:0] ph[8];
    logic signed [31:0] kg[8];
    logic signed [31:0] a[16];
    logic signed [31:0] pn[16];
    logic signed [31:0] det;
    logic signed [63:0] acc;
    for (int i = 0; i < 2; i++) begin
      acc = (i == 0) ? z0 : z1;
      for (int k = 0; k < 4; k++) acc -= rmul(hm[i*4+k], xv[k]);
      y[i] = sat(acc);
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 2; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += rmul(pm[i*4+k], hm[j*4+k]);
        ph[i*2+j] = sat(acc);
      end
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) begin
        acc = rm[i*2+j];
        for (int k = 0; k < 4; k++) acc += rmul(hm[i*4+k], ph[k*2+j]);
        s[i*2+j] = sat(acc);
      end
    det = sat(rmul(s[0], s[3]) - rmul(s[1], s[2]));
    if (det == 0) return 1'b1;
    for (int i = 0; i < 4; i++) begin
      kg[i*2]   = gain(rmul(ph[i*2], s[3]) - rmul(ph[i*2+1], s[2]), det);
      kg[i*2+1] = gain(rmul(ph[i*2+1], s[0]) - rmul(ph[i*2], s[1]), det);
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = (i == j) ? ONE : 0;
        for (int k = 0; k < 2; k++) acc -= rmul(kg[i*2+k], hm[k*4+j]);
        a[i*4+j] = sat(acc);
      end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += rmul(a[i*4+k], pm[k*4+j]);
        pn[i*4+j] = sat(acc);
      end
    for (int i = 0; i < 4; i++) begin
      acc = xv[i];
      for (int k = 0; k < 2; k++) acc += rmul(kg[i*2+k], y[k]);
      xv[i] = sat(acc);
    end
    pm = pn;
    return 1'b0;
  endfunction

  function automatic kf_est_t apply_request(input kf_req_t r);
    kf_est_t e;
    logic sing;
    sing = 1'b0;
    clip = 1'b0;
    case (r.req)
      REQ_LOAD: begin
        n_load++;
        case (r.sel)
          SEL_STATE:  xv[r.row] = r.val;
          SEL_COV:    pm[r.row*4+r.col] = r.val;
          SEL_TRANS:  fm[r.row*4+r.col] = r.val;
          SEL_MEAS:   if (r.row < 2) hm[r.row*4+r.col] = r.val;
          SEL_MNOISE: if (r.row < 2 && r.col < 2) rm[r.row*2+r.col] = r.val;
          SEL_PNOISE: qm[r.row*4+r.col] = r.val;
          default: ;
        endcase
      end
      REQ_PREDICT: begin
        n_pred++;
        run_predict();
      end
      REQ_UPDATE: begin
        n_upd++;
        sing = run_update(r.z0, r.z1);
      end
      default: ;
    endcase
    e.e0 = xv[0];
    e.e1 = xv[1];
    e.e2 = xv[2];
    e.e3 = xv[3];
    e.sing = sing;
    e.sat = clip;
    return e;
  endfunction

  // Request fields arrive as plain integers and are cut to their widths here.
  task automatic queue_req(input int unsigned req, input int unsigned sel,
                           input int unsigned row, input int unsigned col,
                           input logic [31:0] val, input logic [31:0] z0 = '0,
                           input logic [31:0] z1 = '0, input logic hold = 1'b0);
    kf_req_t r;
    r.hold = hold;
    r.req = 2'(req);
    r.sel = 3'(sel);
    r.row = 2'(row);
    r.col = 2'(col);
    r.val = val;
    r.z0 = z0;
    r.z1 = z1;
    pending.push_back(r);
  endtask

  // Signed value within about +/- span/2 in fixed point.
  function automatic logic [31:0] near(input int unsigned span);
    return $urandom_range(0, span) - span / 2;
  endfunction

  // Loads every entry with a well-conditioned filter: near-identity F and H,
  // positive diagonal P, R and Q.
  task automatic load_model(input logic jitter);
    logic [31:0] v;
    for (int i = 0; i < 4; i++) begin
      queue_req(REQ_LOAD, SEL_STATE, i, 0, jitter ? near(32'h0008_0000) : '0);
      for (int j = 0; j < 4; j++) begin
        v = (i == j) ? ONE : '0;
        if (jitter) v += near(32'h0000_4000);
        queue_req(REQ_LOAD, SEL_TRANS, i, j, v);
        v = (i == j) ? ONE + (jitter ? $urandom_range(0, 32'h0002_0000) : 0) : '0;
        queue_req(REQ_LOAD, SEL_COV, i, j, v);
        v = (i == j) ? 32'h0000_0400 + (jitter ? $urandom_range(0, 32'h800) : 0) : '0;
        queue_req(REQ_LOAD, SEL_PNOISE, i, j, v);
        if (i < 2) begin
          v = (i == j) ? ONE : '0;
          if (jitter) v += near(32'h0000_2000);
          queue_req(REQ_LOAD, SEL_MEAS, i, j, v);
          if (j < 2) begin
            v = (i == j) ? 32'h0000_8000 + (jitter ? $urandom_range(0, 32'h8000) : 0)
                         : '0;
            queue_req(REQ_LOAD, SEL_MNOISE, i, j, v);
          end
        end
      end
    end
  endtask

  // Request driver.
  always @(negedge clk_i) begin
    logic nxt_valid;
    nxt_valid = s_valid;
    if (rst_ni) begin
      if (s_valid && in_taken) begin
        nxt_valid = 1'b0;
        gap_left = quiet ? 0 : $urandom_range(0, 11);
      end else if (!s_valid && pending.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (!(pending[0].hold && est_queue.size() != 0)) begin
          cur <= pending.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    s_valid <= nxt_valid;
  end

  // Result receiver back-pressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) stall_left = quiet ? 0 : $urandom_range(0, 11);
      if (stall_left != 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  assign quiet = ((n_in / 120) % 4) == 1;

  // Monitor: checks results, then predicts for the request taken this edge.
  always @(posedge clk_i) begin
    kf_est_t got;
    kf_est_t want;
    if (rst_ni) begin
      in_taken <= s_valid && s_axis_tready;
      out_taken <= m_axis_tvalid && m_ready;
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
        idle_cycles = 0;
      end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
      if (m_axis_tvalid && m_ready) begin
        got = {m_axis_tdata, m_axis_tuser[1], m_axis_tuser[0]};
        n_out++;
        if (got.sing) n_sing++;
        if (got.sat) n_sat++;
        if (est_queue.size() == 0) begin
          if (n_errors < 10) $display("Unexpected result %h", got);
          n_errors++;
        end else begin
          want = est_queue.pop_front();
          if (got !== want) begin
            if (n_errors < 10) begin
              $display("Result %0d mismatch: est %h %h %h %h sing %b sat %b,", n_out,
                       got.e0, got.e1, got.e2, got.e3, got.sing, got.sat);
              $display("  expected %h %h %h %h sing %b sat %b",
                       want.e0, want.e1, want.e2, want.e3, want.sing, want.sat);
            end
            n_errors++;
          end
        end
      end
      if (s_valid && s_axis_tready) begin
        n_in++;
        est_queue.push_back(apply_request(cur));
      end
    end
  end

  initial begin
    int unsigned pick;
    logic hold_done;
    hold_done = 1'b0;

    load_model(1'b0);
    // Extremes of the state, saturating predict and update.
    queue_req(REQ_LOAD, SEL_STATE, 0, 3, 32'h7fff_ffff);
    queue_req(REQ_LOAD, SEL_STATE, 1, 0, 32'h8000_0000);
    queue_req(REQ_PREDICT, SEL_SPARE7, 3, 3, 32'hffff_ffff);
    queue_req(REQ_UPDATE, SEL_STATE, 0, 0, '0, 32'h7fff_ffff, 32'h8000_0000);
    // Loads that must change nothing, and an unknown request.
    queue_req(REQ_LOAD, SEL_SPARE6, 0, 0, 32'h1234_5678);
    queue_req(REQ_LOAD, SEL_SPARE7, 1, 1, 32'hdead_beef);
    queue_req(REQ_LOAD, SEL_MEAS, 2, 0, 32'h0003_0000);
    queue_req(REQ_LOAD, SEL_MNOISE, 0, 3, 32'h0003_0000);
    queue_req(REQ_NOOP, SEL_STATE, 0, 0, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    // Zero H and R make S singular.
    queue_req(REQ_LOAD, SEL_MEAS, 0, 0, '0);
    queue_req(REQ_LOAD, SEL_MEAS, 1, 1, '0);
    queue_req(REQ_LOAD, SEL_MNOISE, 0, 0, '0);
    queue_req(REQ_LOAD, SEL_MNOISE, 1, 1, '0);
    queue_req(REQ_UPDATE, SEL_STATE, 0, 0, '0, 32'h0001_0000, 32'h0002_0000);
    queue_req(REQ_LOAD, SEL_MEAS, 0, 0, ONE);
    queue_req(REQ_LOAD, SEL_MEAS, 1, 1, ONE);
    queue_req(REQ_LOAD, SEL_MNOISE, 0, 0, 32'h0000_8000);
    queue_req(REQ_LOAD, SEL_MNOISE, 1, 1, 32'h0000_8000);
    queue_req(REQ_UPDATE, SEL_STATE, 0, 0, '0, 32'h0000_8000, 32'hffff_8000);
    queue_req(REQ_PREDICT, SEL_STATE, 0, 0, '0);

    while (pending.size() < ITEM_TARGET) begin
      if (pending.size() % 250 < 3) load_model(1'b1);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        queue_req(REQ_PREDICT, $urandom, $urandom, $urandom, $urandom);
        queue_req(REQ_UPDATE, $urandom, $urandom, $urandom, $urandom,
                  near(32'h0010_0000), near(32'h0010_0000),
                  !hold_done && pending.size() > 600);
        if (pending.size() > 600) hold_done = 1'b1;
      end else if (pick < 72) begin
        queue_req(REQ_LOAD, $urandom_range(0, 5), $urandom_range(0, 1),
                  $urandom_range(0, 1), near(32'h0002_0000));
      end else if (pick < 84) begin
        queue_req(REQ_LOAD, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 90) begin
        queue_req(REQ_NOOP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        queue_req(REQ_UPDATE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    do @(posedge clk_i);
    while (pending.size() != 0 || s_valid || est_queue.size() != 0);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d loads, %0d predicts, %0d updates; %0d results checked",
             n_load, n_pred, n_upd, n_out);
    $display("Singular updates seen: %0d, saturating requests: %0d", n_sing, n_sat);
    if (n_errors == 0 && est_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Mismatches: %0d, results outstanding: %0d", n_errors, est_queue.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
